// File: rtl/gdq_pkg.sv
// ----------------------------------------------------------------------------
// gdq_pkg: shared types, constants and elaboration helpers
// Field widths, fixed-point constants, the sequencer state type and the
// constant functions that build the log interpolation table.
// ----------------------------------------------------------------------------
package gdq_pkg;

  localparam int SAMPLE_W = 32;
  localparam int VAR_W    = 32;
  localparam int PRIOR_W  = 16;
  localparam int SCORE_W  = 48;
  localparam int PRIOR_FB = 16;
  localparam int TAB_W    = 30;
  localparam int LN30_W   = 37;
  localparam int QUO_W    = 64;

  // ln(2) in Q30.
  localparam logic signed [LN30_W-1:0] LN2_Q30 = 37'sd744261118;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_SQR,
    S_NORM,
    S_TAB_A,
    S_TAB_B,
    S_MUL,
    S_SUM,
    S_RND,
    S_ACC_LN,
    S_WAIT_DIV,
    S_ACC_Q,
    S_EMIT
  } state_t;

  // Restoring long division, evaluated only while building constants.
  function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + i/2^ltb) in Q30, as 2*atanh(i/(2^(ltb+1)+i)) by its series.
  function automatic logic [TAB_W-1:0] ln1p_entry(input int unsigned i, input int unsigned ltb);
    logic [63:0] den;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] term;
    logic [63:0] sum;
    den  = (64'd1 << (ltb + 1)) + 64'(i);
    z    = cdiv(64'(i) << 30, den);
    z2   = (z * z) >> 30;
    term = z;
    sum  = '0;
    for (int k = 0; k < 40; k++) begin
      if (term != 64'd0) begin
        sum  = sum + cdiv(term, 64'(2 * k + 1));
        term = (term * z2) >> 30;
      end
    end
    return TAB_W'(sum << 1);
  endfunction

endpackage

// File: rtl/gdq_div.sv
// ----------------------------------------------------------------------------
// gdq_div: iterative unsigned divider
// Divides a 64-bit dividend by a 32-bit nonzero divisor, two quotient bits
// per cycle by restoring compare and subtract. The done flag holds until the
// next start.
// ----------------------------------------------------------------------------
module gdq_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gdq_pkg::QUO_W-1:0]  dividend,
  input  logic [gdq_pkg::VAR_W-1:0]  divisor,
  output logic                       done,
  output logic [gdq_pkg::QUO_W-1:0]  quotient
);
  import gdq_pkg::*;

  localparam int STEPS = QUO_W / 2;
  localparam int CW    = $clog2(STEPS);

  logic [VAR_W:0]   rem_r;
  logic [VAR_W:0]   rem_nxt;
  logic [QUO_W-1:0] quo_r;
  logic [QUO_W-1:0] quo_nxt;
  logic [VAR_W-1:0] dsr_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  // Two dependent restoring steps per cycle. The remainder stays below the
  // divisor, so its top bit is free before each shift.
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int j = 0; j < 2; j++) begin
      rem_nxt = {rem_nxt[VAR_W-1:0], quo_nxt[QUO_W-1]};
      quo_nxt = {quo_nxt[QUO_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, dsr_r}) begin
        rem_nxt    = rem_nxt - {1'b0, dsr_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/diag_gaussian_discriminant_score_unit.sv
// ----------------------------------------------------------------------------
// diag_gaussian_discriminant_score_unit: streamed diagonal-Gaussian score
// Accumulates -2*ln(prior) + sum(ln(var) + (x - mean)^2 / var) over the
// feature elements of one sample and class, in saturating fixed point.
//
// Channel  Role      Payload                                       Marks
// in_      request   tdata: sample_value, local_mean,              tuser: first_feature
//                    local_variance, class_prior (low bits first)  tlast: last_feature
// out_     result    tdata: score (48-bit signed)                  tuser: saturated
//
// The element that closes a score adds an emit step, which also waits
// while the output register holds an unaccepted score. The divider sets
// an element's length, two quotient bits at a time, and is started from a
// register after the square step. Both logarithms run on one normalizing
// and interpolating unit in the shadow of the divide.
// Reset (rst_n low, synchronous) clears the sequencer, the accumulator,
// the saturation flag and the output valid; no memory needs clearing.
// A request is taken only in the idle state; a finished score waits in the
// output register while the next request is taken.
// ----------------------------------------------------------------------------
module diag_gaussian_discriminant_score_unit #(
  parameter int FRACTION_BITS     = 16,
  parameter int LOG_TABLE_BITS    = 6,
  parameter int ACCUMULATOR_WIDTH = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata, lowest bit up: sample_value[31:0], local_mean[63:32],
  // local_variance[95:64], class_prior[111:96]
  input  logic [111:0] in_tdata,
  // in_tuser: first_feature
  input  logic         in_tuser,
  input  logic         in_tlast,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_tdata, lowest bit up: score[47:0]
  output logic [47:0]  out_tdata,
  // out_tuser: saturated
  output logic         out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready
);
  import gdq_pkg::*;

  localparam int AW     = ACCUMULATOR_WIDTH;
  localparam int LTB    = LOG_TABLE_BITS;
  localparam int TAB_N  = (1 << LTB) + 1;
  localparam int RW     = 31 - LTB;
  localparam int PW     = TAB_W + RW;
  localparam int RND_SH = 30 - FRACTION_BITS;

  localparam logic signed [LN30_W-1:0] LnHalf   = LN30_W'(64'd1 << (RND_SH - 1));
  localparam logic signed [6:0]        FbVar    = 7'(FRACTION_BITS);
  localparam logic signed [6:0]        FbPrior  = 7'(PRIOR_FB);
  localparam logic [QUO_W-1:0]         AccMax64 = QUO_W'((65'd1 << (AW - 1)) - 65'd1);
  localparam logic [AW-1:0]            AccMax   = {1'b0, {(AW - 1){1'b1}}};
  localparam logic [AW-1:0]            AccMin   = {1'b1, {(AW - 1){1'b0}}};
  localparam logic [2:0]               NormLast = 3'd4;

  // Interpolation table ln(1 + i/2^LTB) in Q30, built at elaboration.
  logic [TAB_W-1:0] ln_tab [TAB_N];
  for (genvar g = 0; g < TAB_N; g++) begin : g_tab
    localparam logic [TAB_W-1:0] Entry = ln1p_entry(g, LTB);
    assign ln_tab[g] = Entry;
  end

  state_t state_r;
  state_t state_nxt;

  // Captured request.
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] m_r;
  logic [VAR_W-1:0]           var_r;
  logic [PRIOR_W-1:0]         prior_r;
  logic                       first_r;
  logic                       last_r;

  // Distance and square.
  logic [SAMPLE_W-1:0]        ad_r;
  logic [QUO_W-1:0]           sq_r;
  logic signed [SAMPLE_W:0]   delta;
  logic                       div_start_r;
  logic                       div_done;
  logic [QUO_W-1:0]           div_quo;

  // Log unit.
  logic [31:0]                n_r;
  logic [4:0]                 z_r;
  logic [2:0]                 step_r;
  logic                       prior_phase_r;
  logic [4:0]                 norm_sh;
  logic [31:0]                norm_mask;
  logic                       norm_top_zero;
  logic [LTB-1:0]             tab_base;
  logic [LTB:0]               tab_idx;
  logic [TAB_W-1:0]           tab_rd;
  logic [RW-1:0]              rem_bits;
  logic [TAB_W-1:0]           ta_r;
  logic [TAB_W-1:0]           diff_r;
  logic [PW-1:0]              prod_r;
  logic [TAB_W:0]             lq;
  logic signed [6:0]          pf;
  logic signed [LN30_W-1:0]   pf_ext;
  logic signed [LN30_W-1:0]   pf_ln2;
  logic signed [LN30_W-1:0]   ln30_r;
  logic signed [LN30_W-1:0]   ln_rnd;
  logic signed [LN30_W-1:0]   ln_r;
  logic signed [LN30_W:0]     neg2_ln;

  // Saturating accumulator.
  logic [AW-1:0]              acc_r;
  logic [AW-1:0]              acc_nxt;
  logic                       sat_r;
  logic                       sat_nxt;
  logic [AW-1:0]              add_a;
  logic [AW-1:0]              add_b;
  logic [AW:0]                add_sum;
  logic                       add_ovf_pos;
  logic                       add_ovf_neg;
  logic [AW-1:0]              add_res;
  logic                       q_big;
  logic [AW-1:0]              q_cap;

  // Output register.
  logic [SCORE_W-1:0]         score_w;
  logic                       score_clamp;
  logic [SCORE_W-1:0]         out_data_r;
  logic                       out_sat_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       out_free;
  logic                       emit_go;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_tvalid) state_nxt = S_DIFF;
      S_DIFF:     state_nxt = S_SQR;
      S_SQR:      state_nxt = S_NORM;
      S_NORM:     if (step_r == NormLast) state_nxt = S_TAB_A;
      S_TAB_A:    state_nxt = S_TAB_B;
      S_TAB_B:    state_nxt = S_MUL;
      S_MUL:      state_nxt = S_SUM;
      S_SUM:      state_nxt = S_RND;
      S_RND:      state_nxt = S_ACC_LN;
      S_ACC_LN:   state_nxt = prior_phase_r ? S_NORM : S_WAIT_DIV;
      S_WAIT_DIV: if (div_done) state_nxt = S_ACC_Q;
      S_ACC_Q:    state_nxt = last_r ? S_EMIT : S_IDLE;
      S_EMIT:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs (handshake, table port, adder operands)
  // --------------------------------------------------------------------------
  always_comb begin
    in_tready = 1'b0;
    tab_idx   = {1'b0, tab_base};
    add_a     = acc_r;
    add_b     = '0;
    emit_go   = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_TAB_B: tab_idx = {1'b0, tab_base} + 1'b1;
      S_ACC_LN: begin
        if (prior_phase_r) begin
          // A new score starts from -2*ln(prior) alone.
          add_a = '0;
          add_b = {{(AW - LN30_W - 1){neg2_ln[LN30_W]}}, neg2_ln};
        end else begin
          add_b = {{(AW - LN30_W){ln_r[LN30_W-1]}}, ln_r};
        end
      end
      S_ACC_Q: add_b = q_cap;
      S_EMIT:  emit_go = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Request capture, distance and square. Zero variance and zero prior are
  // read as one LSB.
  // --------------------------------------------------------------------------
  assign delta = {x_r[SAMPLE_W-1], x_r} - {m_r[SAMPLE_W-1], m_r};

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      x_r     <= in_tdata[31:0];
      m_r     <= in_tdata[63:32];
      var_r   <= (in_tdata[95:64] == '0) ? VAR_W'(1) : in_tdata[95:64];
      prior_r <= (in_tdata[111:96] == '0) ? PRIOR_W'(1) : in_tdata[111:96];
      first_r <= in_tuser;
      last_r  <= in_tlast;
    end
    if (state_r == S_DIFF) begin
      ad_r <= delta[SAMPLE_W] ? SAMPLE_W'(-delta) : SAMPLE_W'(delta);
    end
    if (state_r == S_SQR) begin
      sq_r <= QUO_W'(ad_r) * QUO_W'(ad_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= (state_r == S_SQR);
    end
  end

  gdq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (sq_r),
    .divisor  (var_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // --------------------------------------------------------------------------
  // Log unit. The operand is normalized in five binary steps so that its
  // leading one sits at bit 31; the leading-one position is then 31 - z.
  // The bits below the leading one give the table index, and the rest,
  // top aligned, the interpolation weight.
  // --------------------------------------------------------------------------
  assign norm_sh       = 5'd16 >> step_r;
  assign norm_mask     = ~(32'hFFFF_FFFF >> norm_sh);
  assign norm_top_zero = (n_r & norm_mask) == '0;
  assign tab_base      = n_r[30 -: LTB];
  assign rem_bits      = n_r[RW-1:0];
  assign tab_rd        = ln_tab[tab_idx];

  assign lq      = {1'b0, ta_r} + {1'b0, prod_r[PW-1:RW]};
  assign pf      = $signed({2'b00, 5'd31 - z_r}) - (prior_phase_r ? FbPrior : FbVar);
  assign pf_ext  = {{(LN30_W - 7){pf[6]}}, pf};
  assign pf_ln2  = pf_ext * LN2_Q30;
  assign ln_rnd  = ln30_r + LnHalf;
  assign neg2_ln = '0 - {ln_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_phase_r <= 1'b0;
      step_r        <= '0;
    end else begin
      if (state_r == S_SQR) begin
        prior_phase_r <= first_r;
        step_r        <= '0;
      end else if (state_r == S_ACC_LN) begin
        prior_phase_r <= 1'b0;
        step_r        <= '0;
      end else if (state_r == S_NORM) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_SQR: begin
        n_r <= first_r ? {16'b0, prior_r} : var_r;
        z_r <= '0;
      end
      S_ACC_LN: begin
        n_r <= var_r;
        z_r <= '0;
      end
      S_NORM: begin
        if (norm_top_zero) begin
          n_r <= n_r << norm_sh;
          z_r <= z_r + norm_sh;
        end
      end
      S_TAB_A: ta_r   <= tab_rd;
      S_TAB_B: diff_r <= tab_rd - ta_r;
      S_MUL:   prod_r <= PW'(diff_r) * PW'(rem_bits);
      S_SUM:   ln30_r <= pf_ln2 + $signed({{(LN30_W - TAB_W - 1){1'b0}}, lq});
      S_RND:   ln_r   <= ln_rnd >>> RND_SH;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Saturating accumulator. The quotient is capped at the accumulator's
  // maximum, and the cap counts as saturation.
  // --------------------------------------------------------------------------
  assign q_big       = div_quo > AccMax64;
  assign q_cap       = q_big ? AccMax : div_quo[AW-1:0];
  assign add_sum     = {add_a[AW-1], add_a} + {add_b[AW-1], add_b};
  assign add_ovf_pos = ~add_sum[AW] & add_sum[AW-1];
  assign add_ovf_neg = add_sum[AW] & ~add_sum[AW-1];
  assign add_res     = add_ovf_pos ? AccMax : (add_ovf_neg ? AccMin : add_sum[AW-1:0]);

  always_comb begin
    acc_nxt = acc_r;
    sat_nxt = sat_r;
    case (state_r)
      S_ACC_LN: begin
        acc_nxt = add_res;
        sat_nxt = (prior_phase_r ? 1'b0 : sat_r) | add_ovf_pos | add_ovf_neg;
      end
      S_ACC_Q: begin
        acc_nxt = add_res;
        sat_nxt = sat_r | add_ovf_pos | add_ovf_neg | q_big;
      end
      S_EMIT: begin
        if (emit_go) begin
          acc_nxt = '0;
          sat_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Score range: the accumulator is clamped to the 48-bit score when it is
  // wider, and the clamp marks the result as saturated.
  // --------------------------------------------------------------------------
  if (AW > SCORE_W) begin : g_clamp
    logic [AW-SCORE_W:0] top_bits;
    logic                fits;
    assign top_bits    = acc_r[AW-1:SCORE_W-1];
    assign fits        = (&top_bits) | ~(|top_bits);
    assign score_clamp = ~fits;
    assign score_w     = fits ? acc_r[SCORE_W-1:0]
                              : (acc_r[AW-1] ? {1'b1, {(SCORE_W - 1){1'b0}}}
                                             : {1'b0, {(SCORE_W - 1){1'b1}}});
  end else if (AW == SCORE_W) begin : g_same
    assign score_clamp = 1'b0;
    assign score_w     = acc_r[SCORE_W-1:0];
  end else begin : g_extend
    assign score_clamp = 1'b0;
    assign score_w     = {{(SCORE_W - AW){acc_r[AW-1]}}, acc_r};
  end

  assign out_free = ~out_valid_r | out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r <= score_w;
      out_sat_r  <= sat_r | score_clamp;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;
  assign out_tvalid = out_valid_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The quotient is only added once the divider has finished this element.
  a_quotient_ready : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC_Q) |-> div_done)
    else $error("quotient accumulated before the divider finished");

  // Emitting a score leaves a clean accumulator for the next one.
  a_emit_clears : assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (acc_r == '0 && !sat_r))
    else $error("accumulator or flag not cleared after emission");

  // A result appears only out of the emit step.
  a_out_from_emit : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_EMIT))
    else $error("output valid raised outside the emit step");

endmodule

// File: verif/discriminant_score_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// discriminant_score_checker: score predictor and result comparator
// Watches both stream channels of the discriminant score unit. Every accepted
// feature element is folded into a private copy of the running score, and
// every accepted result is compared with the oldest predicted score.
// ----------------------------------------------------------------------------
module discriminant_score_checker #(
  parameter int FRACTION_BITS     = 16,
  parameter int LOG_TABLE_BITS    = 6,
  parameter int ACCUMULATOR_WIDTH = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [111:0]                in_tdata,
  input  logic                        in_tuser,
  input  logic                        in_tlast,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [gdq_pkg::SCORE_W-1:0] out_tdata,
  input  logic                        out_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  output int                          mismatches,
  output int                          pending_scores,
  output int                          elements_seen,
  output int                          scores_seen,
  output int                          saturated_scores
);
  import gdq_pkg::*;

  localparam longint ACC_MAX   = longint'((64'd1 << (ACCUMULATOR_WIDTH - 1)) - 64'd1);
  localparam longint ACC_MIN   = -ACC_MAX - 1;
  localparam longint SCORE_MAX = longint'((64'd1 << (SCORE_W - 1)) - 64'd1);
  localparam longint SCORE_MIN = -SCORE_MAX - 1;
  localparam int     LUT_SIZE  = (1 << LOG_TABLE_BITS) + 1;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic               saturated;
  } score_result_t;

  score_result_t   expected_scores[$];
  longint unsigned ln1p_lut[LUT_SIZE];
  longint          running_score = 0;
  bit              saturation_sticky = 1'b0;
  int              err_cnt = 0;
  int              elem_cnt = 0;
  int              score_cnt = 0;
  int              sat_cnt = 0;

  // ln(1 + i/2^LOG_TABLE_BITS) in Q30, summed as 2*atanh(z) by its odd series.
  function automatic longint unsigned ln1p_q30(input int unsigned i);
    longint unsigned den, z, z2, term, sum;
    den  = (64'd1 << (LOG_TABLE_BITS + 1)) + 64'(i);
    z    = (64'(i) << 30) / den;
    z2   = (z * z) >> 30;
    term = z;
    sum  = 0;
    for (int k = 0; k < 40 && term != 0; k++) begin
      sum  = sum + term / 64'(2 * k + 1);
      term = (term * z2) >> 30;
    end
    return sum << 1;
  endfunction

  // Natural log of v (fb fraction bits), returned with FRACTION_BITS fraction bits.
  function automatic longint fixed_ln(input longint unsigned v, input int fb);
    longint unsigned idx, rem, lo, hi, interp;
    longint          ln30;
    int              lead, shift;
    if (v == 0) v = 1;
    lead = 0;
    while (lead < 63 && (v >> (lead + 1)) != 0) lead++;
    shift = 0;
    rem   = 0;
    if (lead >= LOG_TABLE_BITS) begin
      shift = lead - LOG_TABLE_BITS;
      idx   = (v >> shift) & ((64'd1 << LOG_TABLE_BITS) - 1);
      rem   = v & ((64'd1 << shift) - 1);
    end else begin
      idx = (v << (LOG_TABLE_BITS - lead)) & ((64'd1 << LOG_TABLE_BITS) - 1);
    end
    lo     = ln1p_lut[idx];
    hi     = ln1p_lut[idx + 1];
    interp = lo + (((hi - lo) * rem) >> shift);
    ln30   = longint'(lead - fb) * longint'(LN2_Q30) + longint'(interp);
    return (ln30 + (longint'(1) <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
  endfunction

  // Adds with clamping to the accumulator range; a clamp marks the score.
  function automatic longint clamp_add(input longint a, input longint b);
    if (b > 0 && a > ACC_MAX - b) begin
      saturation_sticky = 1'b1;
      return ACC_MAX;
    end
    if (b < 0 && a < ACC_MIN - b) begin
      saturation_sticky = 1'b1;
      return ACC_MIN;
    end
    return a + b;
  endfunction

  initial begin
    for (int i = 0; i < LUT_SIZE; i++) ln1p_lut[i] = ln1p_q30(i);
  end

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] sample, mean;
    longint unsigned            variance, prior, sq_quot, abs_diff;
    longint                     diff, score;
    score_result_t              want;
    if (!rst_n) begin
      running_score     = 0;
      saturation_sticky = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        sample   = in_tdata[SAMPLE_W-1:0];
        mean     = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
        variance = 64'(in_tdata[2*SAMPLE_W+VAR_W-1:2*SAMPLE_W]);
        prior    = 64'(in_tdata[2*SAMPLE_W+VAR_W+PRIOR_W-1:2*SAMPLE_W+VAR_W]);
        if (variance == 0) variance = 1;
        if (prior == 0) prior = 1;
        elem_cnt++;
        if (in_tuser) begin
          saturation_sticky = 1'b0;
          running_score     = clamp_add(0, -2 * fixed_ln(prior, PRIOR_FB));
        end
        running_score = clamp_add(running_score, fixed_ln(variance, FRACTION_BITS));
        diff     = longint'(sample) - longint'(mean);
        abs_diff = (diff < 0) ? longint'(-diff) : diff;
        sq_quot  = (abs_diff * abs_diff) / variance;
        if (sq_quot > longint'(ACC_MAX)) begin
          saturation_sticky = 1'b1;
          sq_quot           = ACC_MAX;
        end
        running_score = clamp_add(running_score, longint'(sq_quot));
        if (in_tlast) begin
          score          = running_score;
          want.saturated = saturation_sticky;
          if (score > SCORE_MAX) begin
            score          = SCORE_MAX;
            want.saturated = 1'b1;
          end
          if (score < SCORE_MIN) begin
            score          = SCORE_MIN;
            want.saturated = 1'b1;
          end
          want.score = score[SCORE_W-1:0];
          expected_scores.push_back(want);
          if (want.saturated) sat_cnt++;
          running_score     = 0;
          saturation_sticky = 1'b0;
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_scores.size() == 0) begin
          $error("unexpected score: got 0x%012h, saturated %0b", out_tdata, out_tuser);
          err_cnt++;
        end else begin
          want = expected_scores.pop_front();
          score_cnt++;
          if (out_tdata !== want.score) begin
            $error("score mismatch: expected 0x%012h, got 0x%012h", want.score, out_tdata);
            err_cnt++;
          end
          if (out_tuser !== want.saturated) begin
            $error("saturated mismatch: expected %0b, got %0b", want.saturated, out_tuser);
            err_cnt++;
          end
        end
      end
    end
    mismatches       <= err_cnt;
    pending_scores   <= expected_scores.size();
    elements_seen    <= elem_cnt;
    scores_seen      <= score_cnt;
    saturated_scores <= sat_cnt;
  end

endmodule

// File: verif/diag_gaussian_discriminant_score_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diag_gaussian_discriminant_score_unit_test: regression for the score unit
// Sends directed corner elements and then random feature runs, with random
// gaps on both channels, one long output hold-off and drained pauses. The
// checker beside the block predicts every score and compares each result.
// ----------------------------------------------------------------------------
module diag_gaussian_discriminant_score_unit_test;
  import gdq_pkg::*;

  // Stop sending once about this many feature elements have been taken.
  localparam int ELEMENT_TARGET = 1250;
  // The settle time covers one more element.
  localparam int SETTLE_CYCLES  = 45;
  // The timeout is far above the slowest legal run: every element at full length
  // plus the longest sender gap plus the longest output stall, and the hold-off.
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int HOLDOFF_CYCLES = 600;
  localparam int HOLDOFF_AT     = 300;
  localparam int DRAIN_AT       = 900;
  // Window of elements that runs with no idling on either side.
  localparam int QUIET_LO       = 500;
  localparam int QUIET_HI       = 650;

  logic               clk;
  logic               rst_n;
  logic [111:0]       in_tdata;
  logic               in_tuser;
  logic               in_tlast;
  logic               in_tvalid;
  logic               in_tready;
  logic [SCORE_W-1:0] out_tdata;
  logic               out_tuser;
  logic               out_tvalid;
  logic               out_tready;

  int mismatches;
  int pending_scores;
  int elements_seen;
  int scores_seen;
  int saturated_scores;
  int offered = 0;
  int cycles  = 0;

  diag_gaussian_discriminant_score_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  discriminant_score_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .in_tlast         (in_tlast),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .mismatches       (mismatches),
    .pending_scores   (pending_scores),
    .elements_seen    (elements_seen),
    .scores_seen      (scores_seen),
    .saturated_scores (saturated_scores)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Means sit mostly in a moderate range so that not every score saturates.
  function automatic logic [31:0] pick_mean();
    if ($urandom_range(0, 9) < 3) return $urandom;
    return 32'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
  endfunction

  // Samples land near the mean at a random scale, or anywhere at all.
  function automatic logic [31:0] pick_sample(input logic [31:0] mean);
    int offset;
    if ($urandom_range(0, 3) == 0) return $urandom;
    offset = int'($urandom) >>> $urandom_range(6, 31);
    return mean + 32'(offset);
  endfunction

  // Variances span every magnitude; the tiny range also brings in zero.
  function automatic logic [31:0] pick_variance();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 3);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [15:0] pick_prior();
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 16'hFFFF));
    return 16'($urandom_range(0, 16'hFFFF) >> $urandom_range(0, 15));
  endfunction

  // Most scores span a few features; some are longer, a few much longer.
  function automatic int run_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 6);
    if (roll < 95) return $urandom_range(7, 20);
    return $urandom_range(21, 60);
  endfunction

  // Offers one feature element as a request and holds it until it is taken.
  // Valid stays high straight into the next request when no gap is drawn.
  task automatic offer_element(input logic [31:0] sample, input logic [31:0] mean,
                               input logic [31:0] variance, input logic [15:0] prior,
                               input logic first, input logic last);
    int gap;
    gap = (offered >= QUIET_LO && offered < QUIET_HI) ? 0 : idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {prior, variance, mean, sample};
    in_tuser  <= first;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    offered++;
  endtask

  // Stops sending and waits until every predicted score has come out, then
  // lets one element time pass so no unmarked element is still in flight.
  task automatic wait_for_scores();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_scores != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A well-formed score: first mark on the opening element, last mark on the
  // closing one, one prior for the whole run and random feature content.
  task automatic send_score_run(input int length);
    logic [15:0] prior;
    logic [31:0] mean;
    prior = pick_prior();
    for (int i = 0; i < length; i++) begin
      mean = pick_mean();
      offer_element(pick_sample(mean), mean, pick_variance(), prior,
                    i == 0, i == length - 1);
    end
  endtask

  // Loose elements with random marks: restarts, unmarked openings, short runs.
  task automatic send_noise();
    int count;
    count = $urandom_range(1, 4);
    repeat (count) begin
      offer_element($urandom, $urandom, $urandom, 16'($urandom),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Result side: random stalls, one long hold-off while the sender keeps
  // offering requests, and no stalls at all inside the quiet window.
  initial begin
    int  stall_left;
    bit  holdoff_done;
    out_tready   = 1'b0;
    stall_left   = 0;
    holdoff_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!holdoff_done && elements_seen >= HOLDOFF_AT) begin
        out_tready   <= 1'b0;
        holdoff_done = 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end else if (elements_seen >= QUIET_LO && elements_seen < QUIET_HI) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_gap();
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("diag_gaussian_discriminant_score_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    bit drained_mid_run;
    drained_mid_run = 1'b0;
    rst_n     = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    in_tvalid = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One-element score with unit variance and the largest prior.
    offer_element(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 16'hFFFF, 1'b1, 1'b1);
    // Widest distance over the smallest variance: the quotient hits its cap.
    offer_element(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 16'h0001, 1'b1, 1'b1);
    // Zero variance and zero prior are both taken as one LSB.
    offer_element(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 16'h0000, 1'b1, 1'b1);
    // Largest variance with a mid prior.
    offer_element(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 16'h8000, 1'b1, 1'b1);
    // Elements without a first mark after an emission: no prior term.
    offer_element(32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 16'h1234, 1'b0, 1'b0);
    offer_element(32'hFFFE_0000, 32'h0001_8000, 32'h0000_4000, 16'h4321, 1'b0, 1'b1);
    // A four-feature score.
    offer_element(32'h0001_0000, 32'h0000_8000, 32'h0000_8000, 16'h2000, 1'b1, 1'b0);
    offer_element(32'hFFFF_0000, 32'h0000_0000, 32'h0004_0000, 16'h2000, 1'b0, 1'b0);
    offer_element(32'h0010_0000, 32'h000F_0000, 32'h0100_0000, 16'h2000, 1'b0, 1'b0);
    offer_element(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0100, 16'h2000, 1'b0, 1'b1);
    // A new first mark in the middle of a score throws the partial sum away.
    offer_element(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 16'h0100, 1'b1, 1'b0);
    offer_element(32'h0002_0000, 32'h0000_0000, 32'h0001_0000, 16'h0100, 1'b0, 1'b0);
    offer_element(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 16'h0800, 1'b1, 1'b0);
    offer_element(32'h0000_0000, 32'h0000_8000, 32'h0002_0000, 16'h0800, 1'b0, 1'b1);
    // Two quotients of 2^46 overflow the running sum without hitting the cap.
    offer_element(32'h4000_0000, 32'hC000_0000, 32'h0001_0000, 16'hFFFF, 1'b1, 1'b0);
    offer_element(32'h4000_0000, 32'hC000_0000, 32'h0001_0000, 16'hFFFF, 1'b0, 1'b0);
    offer_element(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 16'hFFFF, 1'b0, 1'b1);
    // A trailing unmarked element; the next score starts with a first mark.
    offer_element(32'h1234_5678, 32'h8765_4321, 32'h0000_0003, 16'h0007, 1'b0, 1'b0);
    wait_for_scores();

    // Random part: mostly well-formed runs, some loose elements.
    while (offered < ELEMENT_TARGET) begin
      if (!drained_mid_run && offered >= DRAIN_AT) begin
        wait_for_scores();
        drained_mid_run = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) send_score_run(run_length());
      else send_noise();
    end
    wait_for_scores();

    $display("Covered %0d feature elements and %0d scores, %0d of them saturated,",
             elements_seen, scores_seen, saturated_scores);
    $display("with corner fields, restarts, random stalls and a %0d-cycle output hold-off.",
             HOLDOFF_CYCLES);
    if (mismatches == 0 && pending_scores == 0) begin
      $display("diag_gaussian_discriminant_score_unit regression: pass");
    end else begin
      $display("diag_gaussian_discriminant_score_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/gdq_pkg.sv
rtl/gdq_div.sv
rtl/diag_gaussian_discriminant_score_unit.sv
verif/discriminant_score_checker.sv
verif/diag_gaussian_discriminant_score_unit_test.sv
